>>> sv/vct_pkg.sv
// Shared types and constants for the viewport cursor tracker.
package vct_pkg;

    localparam int CMD_BITS       = 4;
    localparam int ARG_LINE_BITS  = 32;
    localparam int ARG_COL_BITS   = 16;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CMD_BITS-1:0] CMD_SET       = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_PAGE_DOWN = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_PAGE_UP   = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_PAN_RIGHT = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_PAN_LEFT  = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_ADJ_LINE  = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_ADJ_COL   = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_DOWN      = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_UP        = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_RIGHT     = 4'd9;
    localparam logic [CMD_BITS-1:0] CMD_LEFT      = 4'd10;
    localparam logic [CMD_BITS-1:0] CMD_JUMP_LINE = 4'd11;
    localparam logic [CMD_BITS-1:0] CMD_JUMP_COL  = 4'd12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] HEIGHT_RESET = 13'd23;
    localparam logic [CFG_DATA_BITS-1:0] WIDTH_RESET  = 13'd78;

    typedef struct packed {
        logic [CMD_BITS-1:0]             command;
        logic signed [ARG_LINE_BITS-1:0] line_arg;
        logic [ARG_COL_BITS-1:0]         column_arg;
        logic signed [ARG_LINE_BITS-1:0] window_line_arg;
        logic [ARG_COL_BITS-1:0]         window_column_arg;
        logic                            use_window_size;
    } cmd_t;

endpackage

>>> sv/vct_cmd_if.sv
// Command channel: valid/ready plus one command and its arguments.
interface vct_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic [vct_pkg::CMD_BITS-1:0]             command;
    logic signed [vct_pkg::ARG_LINE_BITS-1:0] line_arg;
    logic [vct_pkg::ARG_COL_BITS-1:0]         column_arg;
    logic signed [vct_pkg::ARG_LINE_BITS-1:0] window_line_arg;
    logic [vct_pkg::ARG_COL_BITS-1:0]         window_column_arg;
    logic                                     use_window_size;

    modport source (
        output valid, command, line_arg, column_arg, window_line_arg,
               window_column_arg, use_window_size,
        input  ready
    );

    modport sink (
        input  valid, command, line_arg, column_arg, window_line_arg,
               window_column_arg, use_window_size,
        output ready
    );
endinterface

>>> sv/vct_pos_if.sv
// Position channel: valid/ready plus cursor and window coordinates.
interface vct_pos_if #(
    parameter int LINE_BITS   = 31,
    parameter int COLUMN_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [LINE_BITS-1:0]   cursor_line_out;
    logic [COLUMN_BITS-1:0] cursor_column_out;
    logic [LINE_BITS-1:0]   window_line_out;
    logic [COLUMN_BITS-1:0] window_column_out;

    modport source (
        output valid, cursor_line_out, cursor_column_out, window_line_out,
               window_column_out,
        input  ready
    );

    modport sink (
        input  valid, cursor_line_out, cursor_column_out, window_line_out,
               window_column_out,
        output ready
    );
endinterface

>>> sv/vct_step.sv
// Next-state logic: applies one command to the cursor and window coordinates.
module vct_step #(
    parameter int LINE_BITS   = 31,
    parameter int COLUMN_BITS = 16
) (
    input  vct_pkg::cmd_t                      cmd,
    input  logic [vct_pkg::CFG_DATA_BITS-1:0]  window_height,
    input  logic [vct_pkg::CFG_DATA_BITS-1:0]  window_width,
    input  logic [LINE_BITS-1:0]               cursor_line,
    input  logic [COLUMN_BITS-1:0]             cursor_column,
    input  logic [LINE_BITS-1:0]               window_line,
    input  logic [COLUMN_BITS-1:0]             window_column,
    output logic [LINE_BITS-1:0]               cursor_line_next,
    output logic [COLUMN_BITS-1:0]             cursor_column_next,
    output logic [LINE_BITS-1:0]               window_line_next,
    output logic [COLUMN_BITS-1:0]             window_column_next
);
    import vct_pkg::*;

    // one spare bit so that a saturating add never wraps
    localparam int LW = ((LINE_BITS > ARG_LINE_BITS) ? LINE_BITS : ARG_LINE_BITS) + 1;
    localparam int CW = ((COLUMN_BITS > ARG_COL_BITS) ? COLUMN_BITS : ARG_COL_BITS) + 1;
    localparam logic [LW-1:0] LMAX = {{(LW-LINE_BITS){1'b0}}, {LINE_BITS{1'b1}}};
    localparam logic [CW-1:0] CMAX = {{(CW-COLUMN_BITS){1'b0}}, {COLUMN_BITS{1'b1}}};

    function automatic logic [LW-1:0] l_add_sat(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW-1:0] s;
        s = a + b;
        return (s > LMAX) ? LMAX : s;
    endfunction

    function automatic logic [LW-1:0] l_sub(input logic [LW-1:0] a, input logic [LW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [CW-1:0] c_add_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW-1:0] s;
        s = a + b;
        return (s > CMAX) ? CMAX : s;
    endfunction

    function automatic logic [CW-1:0] c_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [LW-1:0] l_clamp(input logic signed [ARG_LINE_BITS-1:0] v);
        logic [LW-1:0] p;
        p = LW'(v[ARG_LINE_BITS-2:0]);
        if (v[ARG_LINE_BITS-1])
        begin
            return '0;
        end
        return (p > LMAX) ? LMAX : p;
    endfunction

    logic [LW-1:0]            cl, wl, hl, la_pos, mag, s_cl, s_wl0, s_wl1, jt;
    logic [CW-1:0]            cc, wc, wv, ca, cac, s_wc0, s_wc1;
    logic [ARG_LINE_BITS-1:0] mag32;
    logic [CFG_DATA_BITS-1:0] h13, w13;
    logic                     la_neg;

    assign h13    = (window_height == '0) ? CFG_DATA_BITS'(1) : window_height;
    assign w13    = (window_width == '0) ? CFG_DATA_BITS'(1) : window_width;
    assign hl     = LW'(h13);
    assign wv     = CW'(w13);
    assign cl     = LW'(cursor_line);
    assign wl     = LW'(window_line);
    assign cc     = CW'(cursor_column);
    assign wc     = CW'(window_column);
    assign ca     = CW'(cmd.column_arg);
    assign cac    = (ca > CMAX) ? CMAX : ca;
    assign la_neg = cmd.line_arg[ARG_LINE_BITS-1];
    assign la_pos = la_neg ? '0 : LW'(cmd.line_arg[ARG_LINE_BITS-2:0]);
    assign mag32  = la_neg ? -cmd.line_arg : cmd.line_arg;
    assign mag    = LW'(mag32);

    assign s_cl  = l_clamp(cmd.line_arg);
    assign s_wl0 = l_clamp(cmd.window_line_arg);
    assign s_wl1 = (s_cl < s_wl0) ? s_cl : s_wl0;
    assign s_wc0 = (CW'(cmd.window_column_arg) > CMAX) ? CMAX : CW'(cmd.window_column_arg);
    assign s_wc1 = (cac < s_wc0) ? cac : s_wc0;
    assign jt    = s_cl;

    always_comb
    begin
        logic [LW-1:0] ncl, nwl, dl;
        logic [CW-1:0] ncc, nwc, dc;
        ncl = cl;
        nwl = wl;
        ncc = cc;
        nwc = wc;
        dl  = '0;
        dc  = '0;
        unique case (cmd.command)
            CMD_SET:
            begin
                ncl = s_cl;
                nwl = (s_cl >= s_wl1 + hl) ? l_sub(s_cl, hl - LW'(1)) : s_wl1;
                ncc = cac;
                nwc = (cac >= s_wc1 + wv) ? c_sub(cac, wv - CW'(1)) : s_wc1;
            end
            CMD_PAGE_DOWN:
            begin
                dl  = (cmd.use_window_size || la_neg) ? hl : la_pos;
                nwl = l_add_sat(wl, dl);
                ncl = l_add_sat(cl, dl);
            end
            CMD_PAGE_UP:
            begin
                dl  = (cmd.use_window_size || la_neg) ? hl : la_pos;
                nwl = l_sub(wl, dl);
                ncl = l_sub(cl, dl);
            end
            CMD_PAN_RIGHT:
            begin
                dc  = cmd.use_window_size ? wv : ca;
                nwc = c_add_sat(wc, dc);
                ncc = (cc < nwc) ? nwc : cc;
            end
            CMD_PAN_LEFT:
            begin
                dc  = cmd.use_window_size ? wv : ca;
                nwc = c_sub(wc, dc);
                ncc = (cc >= nwc + wv) ? nwc + wv - CW'(1) : cc;
            end
            CMD_ADJ_LINE:
            begin
                dl  = (la_pos >= hl) ? hl - LW'(1) : la_pos;
                nwl = l_sub(cl, dl);
            end
            CMD_ADJ_COL:
            begin
                dc  = (ca >= wv) ? wv - CW'(1) : ca;
                nwc = c_sub(cc, dc);
            end
            CMD_DOWN, CMD_UP:
            begin
                if ((cmd.command == CMD_DOWN) != la_neg)
                begin
                    ncl = l_add_sat(cl, mag);
                    if (ncl >= wl + hl)
                    begin
                        nwl = l_add_sat(l_sub(ncl, hl), LW'(1));
                    end
                end
                else
                begin
                    ncl = l_sub(cl, mag);
                    if (ncl < wl)
                    begin
                        nwl = ncl;
                    end
                end
            end
            CMD_RIGHT:
            begin
                ncc = c_add_sat(cc, ca);
                if (ncc >= wc + wv)
                begin
                    nwc = c_add_sat(c_sub(ncc, wv), CW'(1));
                end
            end
            CMD_LEFT:
            begin
                if (ca >= cc)
                begin
                    ncc = '0;
                    nwc = '0;
                end
                else
                begin
                    ncc = cc - ca;
                    if (ncc < wc)
                    begin
                        nwc = ncc;
                    end
                end
            end
            CMD_JUMP_LINE:
            begin
                if (!(jt >= wl && jt < wl + hl))
                begin
                    nwl = l_sub(jt, hl >> 1);
                end
                ncl = jt;
            end
            CMD_JUMP_COL:
            begin
                if (!(cac >= wc && cac < wc + wv))
                begin
                    nwc = c_sub(cac, wv >> 1);
                end
                ncc = cac;
            end
            default:
            begin
                ncl = cl;
            end
        endcase
        cursor_line_next   = ncl[LINE_BITS-1:0];
        window_line_next   = nwl[LINE_BITS-1:0];
        cursor_column_next = ncc[COLUMN_BITS-1:0];
        window_column_next = nwc[COLUMN_BITS-1:0];
    end

endmodule

>>> sv/viewport_cursor_tracker.sv
// Top level of the viewport cursor tracker: command register, state and result.
//
//  channel | dir | handshake          | payload
//  cmd     | in  | cmd.valid/ready    | command, line/column args, use_window_size
//  pos     | out | pos.valid/ready    | cursor and window line/column
//  cfg     | in  | cfg_we             | cfg_index, cfg_data (window height/width)
//
// One command per cycle sustained while pos.ready stays high; a result passes through
// the command register, then the coordinate registers, which are also the result.
// The coordinates advance only when the result slot is free, so a stall on pos
// holds one command in the command register and then drops cmd.ready.
// Reset clears all coordinates and loads the default window size.
module viewport_cursor_tracker #(
    parameter int LINE_BITS   = 31,
    parameter int COLUMN_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    vct_cmd_if.sink                             cmd,
    vct_pos_if.source                           pos,
    input  logic                                cfg_we,
    input  logic [vct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [vct_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import vct_pkg::*;

    cmd_t                     cmd_reg;
    logic                     cmd_valid_reg, cmd_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CFG_DATA_BITS-1:0] height_reg, width_reg;
    logic [LINE_BITS-1:0]     cursor_line_reg, cursor_line_next;
    logic [COLUMN_BITS-1:0]   cursor_column_reg, cursor_column_next;
    logic [LINE_BITS-1:0]     window_line_reg, window_line_next;
    logic [COLUMN_BITS-1:0]   window_column_reg, window_column_next;
    logic                     take, fire;

    assign fire      = cmd_valid_reg && (!out_valid_reg || pos.ready);
    assign cmd.ready = !cmd_valid_reg || fire;
    assign take      = cmd.valid && cmd.ready;

    assign cmd_valid_next = take || (cmd_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !pos.ready);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.command           <= cmd.command;
            cmd_reg.line_arg          <= cmd.line_arg;
            cmd_reg.column_arg        <= cmd.column_arg;
            cmd_reg.window_line_arg   <= cmd.window_line_arg;
            cmd_reg.window_column_arg <= cmd.window_column_arg;
            cmd_reg.use_window_size   <= cmd.use_window_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            width_reg  <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data;
            endcase
        end
    end

    vct_step #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_step (
        .cmd                (cmd_reg),
        .window_height      (height_reg),
        .window_width       (width_reg),
        .cursor_line        (cursor_line_reg),
        .cursor_column      (cursor_column_reg),
        .window_line        (window_line_reg),
        .window_column      (window_column_reg),
        .cursor_line_next   (cursor_line_next),
        .cursor_column_next (cursor_column_next),
        .window_line_next   (window_line_next),
        .window_column_next (window_column_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_line_reg   <= '0;
            cursor_column_reg <= '0;
            window_line_reg   <= '0;
            window_column_reg <= '0;
        end
        else if (fire)
        begin
            cursor_line_reg   <= cursor_line_next;
            cursor_column_reg <= cursor_column_next;
            window_line_reg   <= window_line_next;
            window_column_reg <= window_column_next;
        end
    end

    assign pos.valid             = out_valid_reg;
    assign pos.cursor_line_out   = cursor_line_reg;
    assign pos.cursor_column_out = cursor_column_reg;
    assign pos.window_line_out   = window_line_reg;
    assign pos.window_column_out = window_column_reg;

endmodule

>>> tb/tb_viewport_cursor_tracker.sv
// Self-checking testbench for viewport_cursor_tracker: random and directed commands.
module tb_viewport_cursor_tracker;
    import vct_pkg::*;

    localparam int LINE_W = 31;
    localparam int COL_W = 16;
    localparam int RANDOM_PER_SEGMENT = 208;
    localparam int SEGMENTS = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned LINE_LIMIT = (64'd1 << LINE_W) - 1;
    localparam longint unsigned COL_LIMIT = (64'd1 << COL_W) - 1;

    typedef struct packed {
        logic [LINE_W-1:0] cursor_line;
        logic [COL_W-1:0]  cursor_column;
        logic [LINE_W-1:0] window_line;
        logic [COL_W-1:0]  window_column;
    } position_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    vct_cmd_if cmd_bus ();
    vct_pos_if #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W)) pos_bus ();

    viewport_cursor_tracker #(
        .LINE_BITS   (LINE_W),
        .COLUMN_BITS (COL_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .pos       (pos_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cmd_t commands_to_send[$];
    position_t expected_positions[$];
    cmd_t next_cmd;
    cmd_t taken_cmd;
    position_t want;
    bit cmd_taken;
    int send_idle_pct;
    int recv_idle_pct;
    int items_queued;
    int results_seen;
    int error_count;
    int cycle_count;

    // tracked copy of the block's state and window size
    logic [LINE_W-1:0] cur_line;
    logic [COL_W-1:0] cur_col;
    logic [LINE_W-1:0] win_line;
    logic [COL_W-1:0] win_col;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic [CFG_DATA_BITS-1:0] width_reg;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 100)
            $display("ERROR cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic longint unsigned add_sat(input longint unsigned a, b, ceiling);
        longint unsigned x;
        x = (a > ceiling) ? ceiling : a;
        return (b > ceiling - x) ? ceiling : x + b;
    endfunction

    function automatic longint unsigned sub_floor(input longint unsigned a, b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic longint unsigned clamp_line(input logic signed [31:0] v);
        longint sv;
        sv = v;
        return (sv < 0) ? 64'd0 : sv;
    endfunction

    function automatic position_t apply_command(input cmd_t c);
        longint unsigned cl, cc, wl, wc, h, w, d, t, la_mag, ca;
        longint la;
        position_t r;
        cl = cur_line;
        cc = cur_col;
        wl = win_line;
        wc = win_col;
        h = (height_reg == 0) ? 64'd1 : height_reg;
        w = (width_reg == 0) ? 64'd1 : width_reg;
        la = c.line_arg;
        la_mag = (la < 0) ? -la : la;
        ca = c.column_arg;
        case (c.command)
            CMD_SET:
            begin
                cl = clamp_line(c.line_arg);
                cc = ca;
                wl = clamp_line(c.window_line_arg);
                wc = c.window_column_arg;
                if (cl < wl) wl = cl;
                if (cl >= wl + h) wl = sub_floor(cl, h - 1);
                if (cc < wc) wc = cc;
                if (cc >= wc + w) wc = sub_floor(cc, w - 1);
            end
            CMD_PAGE_DOWN, CMD_PAGE_UP:
            begin
                d = (c.use_window_size || la < 0) ? h : la_mag;
                if (c.command == CMD_PAGE_DOWN)
                begin
                    wl = add_sat(wl, d, LINE_LIMIT);
                    cl = add_sat(cl, d, LINE_LIMIT);
                end
                else
                begin
                    wl = sub_floor(wl, d);
                    cl = sub_floor(cl, d);
                end
            end
            CMD_PAN_RIGHT:
            begin
                d = c.use_window_size ? w : ca;
                wc = add_sat(wc, d, COL_LIMIT);
                if (cc < wc) cc = wc;
            end
            CMD_PAN_LEFT:
            begin
                d = c.use_window_size ? w : ca;
                wc = sub_floor(wc, d);
                if (cc >= wc + w) cc = wc + w - 1;
            end
            CMD_ADJ_LINE:
            begin
                t = (la < 0) ? 64'd0 : la_mag;
                if (t >= h) t = h - 1;
                wl = sub_floor(cl, t);
            end
            CMD_ADJ_COL:
            begin
                t = (ca >= w) ? w - 1 : ca;
                wc = sub_floor(cc, t);
            end
            CMD_DOWN, CMD_UP:
            begin
                // a negative count reverses the direction
                if ((c.command == CMD_DOWN) == (la >= 0))
                begin
                    cl = add_sat(cl, la_mag, LINE_LIMIT);
                    if (cl >= wl + h) wl = add_sat(sub_floor(cl, h), 1, LINE_LIMIT);
                end
                else
                begin
                    cl = sub_floor(cl, la_mag);
                    if (cl < wl) wl = cl;
                end
            end
            CMD_RIGHT:
            begin
                cc = add_sat(cc, ca, COL_LIMIT);
                if (cc >= wc + w) wc = add_sat(sub_floor(cc, w), 1, COL_LIMIT);
            end
            CMD_LEFT:
            begin
                if (ca >= cc)
                begin
                    cc = 0;
                    wc = 0;
                end
                else
                begin
                    cc = cc - ca;
                    if (cc < wc) wc = cc;
                end
            end
            CMD_JUMP_LINE:
            begin
                t = clamp_line(c.line_arg);
                if (!(t >= wl && t < wl + h)) wl = sub_floor(t, h / 2);
                cl = t;
            end
            CMD_JUMP_COL:
            begin
                if (!(ca >= wc && ca < wc + w)) wc = sub_floor(ca, w / 2);
                cc = ca;
            end
            default:
            begin
            end
        endcase
        cur_line = cl[LINE_W-1:0];
        cur_col = cc[COL_W-1:0];
        win_line = wl[LINE_W-1:0];
        win_col = wc[COL_W-1:0];
        r.cursor_line = cur_line;
        r.cursor_column = cur_col;
        r.window_line = win_line;
        r.window_column = win_col;
        return r;
    endfunction

    task automatic queue_command(input logic [CMD_BITS-1:0] op, input logic signed [31:0] la,
                                 input logic [15:0] ca, input logic signed [31:0] wla,
                                 input logic [15:0] wca, input logic uws);
        cmd_t c;
        c.command = op;
        c.line_arg = la;
        c.column_arg = ca;
        c.window_line_arg = wla;
        c.window_column_arg = wca;
        c.use_window_size = uws;
        commands_to_send.push_back(c);
        items_queued++;
    endtask

    function automatic logic signed [31:0] random_line_arg();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(40);
            4: return 32'd0 - $urandom_range(40, 1);
            5: return $urandom_range(9000);
            6: return 32'h7FFF_FFFF - $urandom_range(64);
            7: return 32'h8000_0000 + $urandom_range(64);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] random_column_arg();
        logic [31:0] v;
        case ($urandom_range(7))
            0, 1, 2, 3: v = $urandom_range(100);
            4: v = $urandom_range(9000);
            5: v = 32'd65535 - $urandom_range(64);
            default: v = $urandom();
        endcase
        return v[15:0];
    endfunction

    task automatic queue_random_command();
        logic [31:0] op;
        op = $urandom_range(15);
        queue_command(op[CMD_BITS-1:0], random_line_arg(), random_column_arg(),
                      random_line_arg(), random_column_arg(), 1'($urandom_range(1)));
    endtask

    task automatic wait_for_results();
        while (results_seen < items_queued)
            @(negedge clk);
    endtask

    task automatic write_window_size(input logic [CFG_DATA_BITS-1:0] h,
                                     input logic [CFG_DATA_BITS-1:0] w);
        cfg_we <= 1'b1;
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_bus.valid || cmd_taken)
            begin
                if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = commands_to_send.pop_front();
                    cmd_bus.command <= next_cmd.command;
                    cmd_bus.line_arg <= next_cmd.line_arg;
                    cmd_bus.column_arg <= next_cmd.column_arg;
                    cmd_bus.window_line_arg <= next_cmd.window_line_arg;
                    cmd_bus.window_column_arg <= next_cmd.window_column_arg;
                    cmd_bus.use_window_size <= next_cmd.use_window_size;
                    cmd_bus.valid <= 1'b1;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
            pos_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: config tracking, prediction on each command transfer, result checks
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            if (rst_n && cfg_we)
            begin
                if (cfg_index == CFG_HEIGHT)
                    height_reg = cfg_data;
                else
                    width_reg = cfg_data;
            end
            if (rst_n && pos_bus.valid && pos_bus.ready)
            begin
                results_seen++;
                if (expected_positions.size() == 0)
                begin
                    report_mismatch("result transfer with no command outstanding");
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (pos_bus.cursor_line_out !== want.cursor_line)
                        report_mismatch($sformatf("cursor_line got %0d want %0d",
                                        pos_bus.cursor_line_out, want.cursor_line));
                    if (pos_bus.cursor_column_out !== want.cursor_column)
                        report_mismatch($sformatf("cursor_column got %0d want %0d",
                                        pos_bus.cursor_column_out, want.cursor_column));
                    if (pos_bus.window_line_out !== want.window_line)
                        report_mismatch($sformatf("window_line got %0d want %0d",
                                        pos_bus.window_line_out, want.window_line));
                    if (pos_bus.window_column_out !== want.window_column)
                        report_mismatch($sformatf("window_column got %0d want %0d",
                                        pos_bus.window_column_out, want.window_column));
                end
            end
            cmd_taken = rst_n && cmd_bus.valid && cmd_bus.ready;
            if (cmd_taken)
            begin
                taken_cmd.command = cmd_bus.command;
                taken_cmd.line_arg = cmd_bus.line_arg;
                taken_cmd.column_arg = cmd_bus.column_arg;
                taken_cmd.window_line_arg = cmd_bus.window_line_arg;
                taken_cmd.window_column_arg = cmd_bus.window_column_arg;
                taken_cmd.use_window_size = cmd_bus.use_window_size;
                expected_positions.push_back(apply_command(taken_cmd));
            end
        end
    end

    initial
    begin
        int seg;
        logic [CFG_DATA_BITS-1:0] seg_height[SEGMENTS];
        logic [CFG_DATA_BITS-1:0] seg_width[SEGMENTS];
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_SET;
        cmd_bus.line_arg = '0;
        cmd_bus.column_arg = '0;
        cmd_bus.window_line_arg = '0;
        cmd_bus.window_column_arg = '0;
        cmd_bus.use_window_size = 1'b0;
        pos_bus.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEIGHT;
        cfg_data = '0;
        cmd_taken = 1'b0;
        cycle_count = 0;
        items_queued = 0;
        results_seen = 0;
        error_count = 0;
        cur_line = '0;
        cur_col = '0;
        win_line = '0;
        win_col = '0;
        height_reg = HEIGHT_RESET;
        width_reg = WIDTH_RESET;
        send_idle_pct = 13;
        recv_idle_pct = 49;
        seg_height = '{13'd1, 13'd8191, 13'd0, 13'd0, 13'd4096, 13'd7};
        seg_width = '{13'd1, 13'd8191, 13'd0, 13'd0, 13'd2, 13'd4096};
        seg_height[3] = CFG_DATA_BITS'($urandom_range(64, 2));
        seg_width[3] = CFG_DATA_BITS'($urandom_range(200, 2));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every command, negative and oversized arguments
        queue_command(CMD_SET, 5, 7, 0, 0, 1'b0);
        queue_command(CMD_SET, -1, 0, -5, 0, 1'b0);
        queue_command(CMD_SET, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000, 0, 1'b0);
        queue_command(CMD_DOWN, 5, 0, 0, 0, 1'b0);
        queue_command(CMD_PAGE_DOWN, 100, 0, 0, 0, 1'b0);
        queue_command(CMD_SET, 100, 100, 90, 90, 1'b0);
        queue_command(CMD_PAGE_DOWN, -3, 0, 0, 0, 1'b0);
        queue_command(CMD_PAGE_UP, 0, 0, 0, 0, 1'b1);
        queue_command(CMD_PAGE_UP, 1000, 0, 0, 0, 1'b0);
        queue_command(CMD_PAN_RIGHT, 0, 0, 0, 0, 1'b1);
        queue_command(CMD_PAN_RIGHT, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(CMD_PAN_LEFT, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(CMD_PAN_LEFT, 0, 0, 0, 0, 1'b1);
        queue_command(CMD_ADJ_LINE, -7, 0, 0, 0, 1'b0);
        queue_command(CMD_ADJ_LINE, 32'h7FFF_FFFF, 0, 0, 0, 1'b0);
        queue_command(CMD_ADJ_COL, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(CMD_ADJ_COL, 0, 3, 0, 0, 1'b0);
        queue_command(CMD_DOWN, 32'h8000_0000, 0, 0, 0, 1'b0);
        queue_command(CMD_UP, 32'h8000_0000, 0, 0, 0, 1'b0);
        queue_command(CMD_UP, 50, 0, 0, 0, 1'b0);
        queue_command(CMD_RIGHT, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(CMD_LEFT, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(CMD_JUMP_LINE, 32'h8000_0000, 0, 0, 0, 1'b0);
        queue_command(CMD_JUMP_LINE, 1000000, 0, 0, 0, 1'b0);
        queue_command(CMD_JUMP_COL, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_command(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        wait_for_results();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_window_size(seg_height[seg], seg_width[seg]);
            repeat (RANDOM_PER_SEGMENT) queue_random_command();
            wait_for_results();
        end

        repeat (8) @(posedge clk);
        if (expected_positions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_positions.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
